@@ design/wst_pkg.sv @@
package wst_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 8;
    localparam int AVG_W      = 24;
    localparam int SPREAD_W   = 38;
    localparam int DEV_W      = 23;
    localparam int REL_W      = 16;
    localparam int RANGE_W    = 16;
    localparam int SCORE_W    = 8;
    localparam int TOTAL_W    = 10;
    localparam int EXCEED_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // square root operand: spread (< 2^38) with FRAC_W more fraction bits
    localparam int ROOT_W     = 48;
    localparam int ROOT_STEPS = ROOT_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0] REG_LOW_SCORE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_SCORE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELATIVE_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_SUM_LIMIT = 3'd6;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

endpackage

@@ design/wst_div.sv @@
module wst_div #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output logic                 done,
    output logic [NUM_W-1:0]     quot
);
    // restoring divider, one quotient bit per cycle
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, quot_reg[NUM_W-1]};
        fits  = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_next = {quot_reg[NUM_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ design/window_statistics_thresholder.sv @@
// Window statistics thresholder.
// Input: an item (sample, last) is taken at a clock edge with start high and
// busy low. Samples without last are accumulated in that same cycle (sum,
// sum of squares, min, max, count) and busy stays low, so one sample per
// cycle is possible. Samples past WINDOW_MAX are dropped from the window.
// An item with last closes the window: busy rises and a sequencer runs the
// feature math on one shared restoring divider (one quotient bit per cycle)
// and a bit-pair square root step. The divider runs for mean, variance and
// relative deviation, with the square root between the last two; the
// relative division is skipped when the mean is zero. Next item is
// accepted in the cycle done is high.
// Output: every field is valid when done is high and held until the next
// result; the receiver cannot stall. Configuration: wr_en/wr_index/wr_data write one
// register per edge; indexes beyond the list are ignored. Write only while
// idle. Reset clears the window and loads the register defaults.
module window_statistics_thresholder #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [wst_pkg::SAMPLE_W-1:0]    sample,
    input  logic                                   last,
    input  logic                                   wr_en,
    input  logic [wst_pkg::CFG_IDX_W-1:0]          wr_index,
    input  logic [wst_pkg::CFG_DATA_W-1:0]         wr_data,
    output logic                                   done,
    output logic signed [wst_pkg::AVG_W-1:0]       avg,
    output logic [wst_pkg::SPREAD_W-1:0]           spread,
    output logic [wst_pkg::DEV_W-1:0]              deviation,
    output logic signed [wst_pkg::REL_W-1:0]       relative_deviation,
    output logic [wst_pkg::RANGE_W-1:0]            peak_range,
    output logic [wst_pkg::SCORE_W-1:0]            avg_score,
    output logic [wst_pkg::SCORE_W-1:0]            deviation_score,
    output logic [wst_pkg::SCORE_W-1:0]            relative_score,
    output logic [wst_pkg::SCORE_W-1:0]            range_score,
    output logic [wst_pkg::TOTAL_W-1:0]            score_total,
    output logic [wst_pkg::SCORE_W-1:0]            total_score,
    output logic [wst_pkg::EXCEED_W-1:0]           exceed_count
);
    import wst_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;          // signed running sum
    localparam int SQ_W   = 2 * SAMPLE_W - 2 + CNT_W;  // sum of squares
    localparam int PROD_W = SQ_W + CNT_W;              // n*Q and sum^2
    localparam int N2_W   = 2 * CNT_W;
    localparam int NUM_A  = PROD_W + FRAC_W + 1;
    localparam int NUM_B  = DEV_W + FRAC_W + 1;
    localparam int NUM_W  = (NUM_A > NUM_B) ? NUM_A : NUM_B;
    localparam int DEN_W  = (N2_W > AVG_W) ? N2_W : AVG_W;
    localparam int MA_W   = SUM_W;                     // multiplier operand a
    localparam int MB_W   = SQ_W;                      // multiplier operand b

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MUL_NQ   = 4'd1;
    localparam logic [3:0] S_MUL_SS   = 4'd2;
    localparam logic [3:0] S_DIFF     = 4'd3;
    localparam logic [3:0] S_AVG_GO   = 4'd4;
    localparam logic [3:0] S_AVG_WAIT = 4'd5;
    localparam logic [3:0] S_VAR_WAIT = 4'd6;
    localparam logic [3:0] S_ROOT     = 4'd7;
    localparam logic [3:0] S_ROOT_FIN = 4'd8;
    localparam logic [3:0] S_REL_GO   = 4'd9;
    localparam logic [3:0] S_REL_WAIT = 4'd10;
    localparam logic [3:0] S_SCORE    = 4'd11;

    localparam logic [NUM_W-1:0] AVG_POS_MAX = NUM_W'(24'h7FFFFF);
    localparam logic [NUM_W-1:0] AVG_NEG_MAX = NUM_W'(24'h800000);
    localparam logic [NUM_W-1:0] SPREAD_MAX  = NUM_W'(38'h3FFFFFFFFF);
    localparam logic [NUM_W-1:0] REL_POS_MAX = NUM_W'(16'h7FFF);
    localparam logic [NUM_W-1:0] REL_NEG_MAX = NUM_W'(17'h08000);
    localparam logic [ROOT_W:0]  DEV_MAX     = (ROOT_W+1)'(23'h7FFFFF);

    // configuration
    logic [SCORE_W-1:0]         low_score_reg, high_score_reg;
    logic signed [AVG_W-1:0]    mean_limit_reg;
    logic [DEV_W-1:0]           deviation_limit_reg;
    logic signed [REL_W-1:0]    relative_limit_reg;
    logic [RANGE_W-1:0]         range_limit_reg;
    logic [TOTAL_W-1:0]         score_sum_limit_reg;

    // window accumulators
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next, max_reg, max_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    // sequencer and datapath
    logic [3:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [SUM_W-1:0]           mag_reg, mag_next;
    logic                       neg_reg, neg_next;
    logic [PROD_W-1:0]          nq_reg, nq_next;
    logic [PROD_W-1:0]          d_reg, d_next;
    logic [N2_W-1:0]            n2_reg, n2_next;
    logic signed [AVG_W-1:0]    avg_reg, avg_next;
    logic [SPREAD_W-1:0]        spread_reg, spread_next;
    logic [ROOT_W-1:0]          rv_reg, rv_next;
    logic [ROOT_W-1:0]          res_reg, res_next;
    logic [ROOT_W-1:0]          bit_reg, bit_next;
    logic [ROOT_CNT_W-1:0]      rcnt_reg, rcnt_next;
    logic [DEV_W-1:0]           dev_reg, dev_next;
    logic signed [REL_W-1:0]    rel_reg, rel_next;
    logic                       done_reg, done_next;

    // output registers
    logic signed [AVG_W-1:0]    o_avg_reg;
    logic [SPREAD_W-1:0]        o_spread_reg;
    logic [DEV_W-1:0]           o_dev_reg;
    logic signed [REL_W-1:0]    o_rel_reg;
    logic [RANGE_W-1:0]         o_rng_reg;
    logic [SCORE_W-1:0]         o_sa_reg, o_sd_reg, o_sr_reg, o_sg_reg, o_st_reg;
    logic [TOTAL_W-1:0]         o_tot_reg;
    logic [EXCEED_W-1:0]        o_cnt_reg;

    // shared multiplier
    logic [MA_W-1:0]            mul_a;
    logic [MB_W-1:0]            mul_b;
    logic [MA_W+MB_W-1:0]       mul_p;

    // divider
    logic                       div_go;
    logic                       div_done;
    logic [NUM_W-1:0]           div_num;
    logic [DEN_W-1:0]           div_den;
    logic [NUM_W-1:0]           div_quot;

    // misc combinational
    logic                       accept;
    logic [ROOT_W-1:0]          root_trial;
    logic [ROOT_W:0]            root_up;
    logic [NUM_W-1:0]           qclamp;
    logic [AVG_W:0]             avg_wide;
    logic [REL_W:0]             rel_wide;
    logic [AVG_W-1:0]           avg_mag;
    logic [RANGE_W-1:0]         rng;
    logic                       ea, ed, er, eg, et;
    logic [SCORE_W-1:0]         sa, sd, sr, sg;
    logic [TOTAL_W-1:0]         tot;
    logic signed [2*SAMPLE_W-1:0] sq_sample;

    assign accept = start && !busy;
    assign busy   = state_reg != S_IDLE;

    wst_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign mul_a = (state_reg == S_MUL_NQ) ? MA_W'(n_reg) : mag_reg;
    assign mul_b = (state_reg == S_MUL_NQ) ? sq_reg : MB_W'(mag_reg);
    assign mul_p = mul_a * mul_b;

    assign sq_sample = sample * sample;

    always_comb
    begin
        // window accumulation
        sum_next = sum_reg;
        sq_next  = sq_reg;
        min_next = min_reg;
        max_next = max_reg;
        cnt_next = cnt_reg;
        if (accept && cnt_reg < CNT_W'(WINDOW_MAX))
        begin
            sum_next = sum_reg + SUM_W'(sample);
            sq_next  = sq_reg + SQ_W'(unsigned'(sq_sample));
            if (sample < min_reg)
                min_next = sample;
            if (sample > max_reg)
                max_next = sample;
            cnt_next = cnt_reg + 1'b1;
        end

        state_next  = state_reg;
        n_next      = n_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        nq_next     = nq_reg;
        d_next      = d_reg;
        n2_next     = n2_reg;
        avg_next    = avg_reg;
        spread_next = spread_reg;
        rv_next     = rv_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        rcnt_next   = rcnt_reg;
        dev_next    = dev_reg;
        rel_next    = rel_reg;
        done_next   = 1'b0;
        div_go      = 1'b0;
        div_num     = '0;
        div_den     = '0;

        root_trial = res_reg + bit_reg;
        root_up    = {1'b0, res_reg} + (ROOT_W+1)'(rv_reg > res_reg);
        qclamp     = '0;
        avg_wide   = '0;
        rel_wide   = '0;
        avg_mag    = avg_reg[AVG_W-1] ? AVG_W'(-avg_reg) : AVG_W'(avg_reg);

        rng = RANGE_W'(max_reg - min_reg);
        ea  = avg_reg > mean_limit_reg;
        ed  = dev_reg > deviation_limit_reg;
        er  = rel_reg > relative_limit_reg;
        eg  = rng > range_limit_reg;
        sa  = ea ? high_score_reg : low_score_reg;
        sd  = ed ? high_score_reg : low_score_reg;
        sr  = er ? high_score_reg : low_score_reg;
        sg  = eg ? high_score_reg : low_score_reg;
        tot = TOTAL_W'(sa) + TOTAL_W'(sd) + TOTAL_W'(sr) + TOTAL_W'(sg);
        et  = tot > score_sum_limit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && last)
                begin
                    // window closes: latch n and |sum| from the updated values
                    n_next    = (cnt_next == '0) ? CNT_W'(1) : cnt_next;
                    neg_next  = sum_next < 0;
                    mag_next  = (sum_next < 0) ? SUM_W'(-sum_next) : SUM_W'(sum_next);
                    state_next = S_MUL_NQ;
                end
            end
            S_MUL_NQ:
            begin
                nq_next    = PROD_W'(mul_p);
                state_next = S_MUL_SS;
            end
            S_MUL_SS:
            begin
                d_next     = nq_reg - PROD_W'(mul_p);
                n2_next    = N2_W'(n_reg) * N2_W'(n_reg);
                state_next = S_AVG_GO;
            end
            S_DIFF:
            begin
                state_next = S_AVG_GO;
            end
            S_AVG_GO:
            begin
                div_go     = 1'b1;
                div_num    = (NUM_W'(mag_reg) << FRAC_W) + NUM_W'(n_reg >> 1);
                div_den    = DEN_W'(n_reg);
                state_next = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                        qclamp = (div_quot > AVG_NEG_MAX) ? AVG_NEG_MAX : div_quot;
                    else
                        qclamp = (div_quot > AVG_POS_MAX) ? AVG_POS_MAX : div_quot;
                    avg_wide   = neg_reg ? -(AVG_W+1)'(qclamp) : (AVG_W+1)'(qclamp);
                    avg_next   = avg_wide[AVG_W-1:0];
                    // variance: (d*2^F + n^2/2) / n^2
                    div_go     = 1'b1;
                    div_num    = (NUM_W'(d_reg) << FRAC_W) + NUM_W'(n2_reg >> 1);
                    div_den    = DEN_W'(n2_reg);
                    state_next = S_VAR_WAIT;
                end
            end
            S_VAR_WAIT:
            begin
                if (div_done)
                begin
                    spread_next = (div_quot > SPREAD_MAX) ? SPREAD_W'(SPREAD_MAX)
                                                          : SPREAD_W'(div_quot);
                    rv_next     = ROOT_W'(div_quot) << FRAC_W;
                    res_next    = '0;
                    bit_next    = ROOT_W'(1) << (ROOT_W - 2);
                    rcnt_next   = ROOT_CNT_W'(ROOT_STEPS);
                    state_next  = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (rv_reg >= root_trial)
                begin
                    rv_next  = rv_reg - root_trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                rcnt_next = rcnt_reg - 1'b1;
                if (rcnt_reg == ROOT_CNT_W'(1))
                    state_next = S_ROOT_FIN;
            end
            S_ROOT_FIN:
            begin
                // round to nearest: remainder above the root means next integer
                dev_next   = (root_up > DEV_MAX) ? DEV_W'(DEV_MAX) : DEV_W'(root_up);
                state_next = S_REL_GO;
            end
            S_REL_GO:
            begin
                if (avg_reg == '0)
                begin
                    rel_next   = REL_W'(REL_POS_MAX);
                    state_next = S_SCORE;
                end
                else
                begin
                    div_go     = 1'b1;
                    div_num    = (NUM_W'(dev_reg) << FRAC_W) + NUM_W'(avg_mag >> 1);
                    div_den    = DEN_W'(avg_mag);
                    state_next = S_REL_WAIT;
                end
            end
            S_REL_WAIT:
            begin
                if (div_done)
                begin
                    if (avg_reg[AVG_W-1])
                        qclamp = (div_quot > REL_NEG_MAX) ? REL_NEG_MAX : div_quot;
                    else
                        qclamp = (div_quot > REL_POS_MAX) ? REL_POS_MAX : div_quot;
                    rel_wide   = avg_reg[AVG_W-1] ? -(REL_W+1)'(qclamp)
                                                  : (REL_W+1)'(qclamp);
                    rel_next   = rel_wide[REL_W-1:0];
                    state_next = S_SCORE;
                end
            end
            S_SCORE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                sum_next   = '0;
                sq_next    = '0;
                min_next   = SAMPLE_MAX;
                max_next   = SAMPLE_MIN;
                cnt_next   = '0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            done_reg            <= 1'b0;
            sum_reg             <= '0;
            sq_reg              <= '0;
            min_reg             <= SAMPLE_MAX;
            max_reg             <= SAMPLE_MIN;
            cnt_reg             <= '0;
            low_score_reg       <= '0;
            high_score_reg      <= SCORE_W'(1);
            mean_limit_reg      <= '0;
            deviation_limit_reg <= '0;
            relative_limit_reg  <= '0;
            range_limit_reg     <= '0;
            score_sum_limit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            sum_reg   <= sum_next;
            sq_reg    <= sq_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            cnt_reg   <= cnt_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_LOW_SCORE:       low_score_reg       <= wr_data[SCORE_W-1:0];
                    REG_HIGH_SCORE:      high_score_reg      <= wr_data[SCORE_W-1:0];
                    REG_MEAN_LIMIT:      mean_limit_reg      <= wr_data[AVG_W-1:0];
                    REG_DEVIATION_LIMIT: deviation_limit_reg <= wr_data[DEV_W-1:0];
                    REG_RELATIVE_LIMIT:  relative_limit_reg  <= wr_data[REL_W-1:0];
                    REG_RANGE_LIMIT:     range_limit_reg     <= wr_data[RANGE_W-1:0];
                    REG_SCORE_SUM_LIMIT: score_sum_limit_reg <= wr_data[TOTAL_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        nq_reg     <= nq_next;
        d_reg      <= d_next;
        n2_reg     <= n2_next;
        avg_reg    <= avg_next;
        spread_reg <= spread_next;
        rv_reg     <= rv_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        rcnt_reg   <= rcnt_next;
        dev_reg    <= dev_next;
        rel_reg    <= rel_next;
        if (state_reg == S_SCORE)
        begin
            o_avg_reg    <= avg_reg;
            o_spread_reg <= spread_reg;
            o_dev_reg    <= dev_reg;
            o_rel_reg    <= rel_reg;
            o_rng_reg    <= rng;
            o_sa_reg     <= sa;
            o_sd_reg     <= sd;
            o_sr_reg     <= sr;
            o_sg_reg     <= sg;
            o_tot_reg    <= tot;
            o_st_reg     <= et ? high_score_reg : low_score_reg;
            o_cnt_reg    <= EXCEED_W'(ea) + EXCEED_W'(ed) + EXCEED_W'(er)
                          + EXCEED_W'(eg) + EXCEED_W'(et);
        end
    end

    assign done               = done_reg;
    assign avg                = o_avg_reg;
    assign spread             = o_spread_reg;
    assign deviation          = o_dev_reg;
    assign relative_deviation = o_rel_reg;
    assign peak_range         = o_rng_reg;
    assign avg_score          = o_sa_reg;
    assign deviation_score    = o_sd_reg;
    assign relative_score     = o_sr_reg;
    assign range_score        = o_sg_reg;
    assign score_total        = o_tot_reg;
    assign total_score        = o_st_reg;
    assign exceed_count       = o_cnt_reg;

    // a record only follows the scoring step
    a_done_after_score: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_SCORE))
        else $error("done without scoring step");

    // divider results only arrive while the sequencer waits on them
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_AVG_WAIT || state_reg == S_VAR_WAIT
                      || state_reg == S_REL_WAIT))
        else $error("divider result with no consumer");

    // the window never holds more than its maximum
    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(WINDOW_MAX))
        else $error("window count overflow");

    // the exceed count never exceeds the five limits
    a_exceed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> exceed_count <= EXCEED_W'(5))
        else $error("exceed count out of range");

endmodule
